/* design/plist_pkg.sv */
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and constants for the positional list unit: command codes,
// status codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package plist_pkg;

   // Default sizes for the top-level parameters
   localparam int CapacityDefault     = 64;
   localparam int ElementWidthDefault = 32;

   // Fixed field widths
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;

   // Command codes; the two unused codes fall to the default arm
   typedef enum logic [CMD_W-1:0] {
      CMD_INS_HEAD = 3'd0,
      CMD_INS_TAIL = 3'd1,
      CMD_INS_AT   = 3'd2,
      CMD_REM_HEAD = 3'd3,
      CMD_REM_TAIL = 3'd4,
      CMD_REM_AT   = 3'd5
   } cmd_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

endpackage

`default_nettype wire

/* design/plist_ram.sv */
// ----------------------------------------------------------------------------
// plist_ram
// Generic single-clock RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module plist_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 64,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write, and register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* design/positional_list_insert_remove_unit.sv */
// ----------------------------------------------------------------------------
// positional_list_insert_remove_unit
// Ordered list of up to CAPACITY element words held in one RAM. Inserts and
// removes at head, tail or a given position, shifting entries one a cycle.
// ----------------------------------------------------------------------------
//  channel | direction | transfer carries
//  --------+-----------+------------------------------------------------------
//  req_    | in        | cmd, position, element_in
//  rsp_    | out       | element_out, status, count_after
//
//  An item runs shortest for a rejected command and longest for an insert
//  at the head of the list, set by the one RAM read and one RAM write per
//  cycle of the shift walk.
//  Reset empties the list at once; no clearing pass is needed.
//  A result waits in the output register while the next item is taken; a
//  stalled rsp_ side holds the sequencer in its result state.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_remove_unit #(
   parameter int  CAPACITY      = plist_pkg::CapacityDefault,
   parameter int  ELEMENT_WIDTH = plist_pkg::ElementWidthDefault,
   localparam int PosW  = $clog2(CAPACITY + 1),
   localparam int ReqW  = ((plist_pkg::CMD_W + PosW + ELEMENT_WIDTH + 7) / 8) * 8,
   localparam int RspW  = ((ELEMENT_WIDTH + plist_pkg::STATUS_W + PosW + 7) / 8) * 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   // cmd, position, element_in (lowest bit first)
   input  wire logic [ReqW-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   // element_out, status, count_after (lowest bit first)
   output logic      [RspW-1:0] rsp_tdata
);

   localparam int AddrW = $clog2(CAPACITY);
   localparam int CmdW  = plist_pkg::CMD_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_SHIFT,
      S_INS_PLACE,
      S_REM_TAKE,
      S_REM_SHIFT,
      S_RESP
   } state_type;

   state_type                state_ff, state_in;
   logic [PosW-1:0]          count_ff, count_in;
   logic [AddrW-1:0]         ptr_ff, ptr_in;
   logic [AddrW-1:0]         pos_ff, pos_in;
   logic [AddrW-1:0]         end_ff, end_in;
   logic [ELEMENT_WIDTH-1:0] value_ff, value_in;
   logic [ELEMENT_WIDTH-1:0] taken_ff, taken_in;
   plist_pkg::status_type    status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RspW-1:0]          rsp_data_ff, rsp_data_in;

   // Request fields
   plist_pkg::cmd_type       req_cmd;
   logic [PosW-1:0]          req_pos;
   logic [ELEMENT_WIDTH-1:0] req_elem;

   // Decoded command
   logic                     is_ins;
   logic                     is_rem;
   logic [PosW-1:0]          dec_pos;

   // RAM port
   logic                     ram_wr_en;
   logic [AddrW-1:0]         ram_wr_addr;
   logic [ELEMENT_WIDTH-1:0] ram_wr_data;
   logic                     ram_rd_en;
   logic [AddrW-1:0]         ram_rd_addr;
   logic [ELEMENT_WIDTH-1:0] ram_rd_data;

   // Unpack the request
   assign req_cmd  = plist_pkg::cmd_type'(req_tdata[CmdW-1:0]);
   assign req_pos  = req_tdata[CmdW+PosW-1:CmdW];
   assign req_elem = req_tdata[CmdW+PosW+ELEMENT_WIDTH-1:CmdW+PosW];

   // Resolve each defined command to insert or remove at one index
   always_comb begin
      is_ins  = 1'b0;
      is_rem  = 1'b0;
      dec_pos = '0;
      case (req_cmd)
         plist_pkg::CMD_INS_HEAD: begin
            is_ins = 1'b1;
         end
         plist_pkg::CMD_INS_TAIL: begin
            is_ins  = 1'b1;
            dec_pos = count_ff;
         end
         plist_pkg::CMD_INS_AT: begin
            is_ins  = 1'b1;
            dec_pos = req_pos;
         end
         plist_pkg::CMD_REM_HEAD: begin
            is_rem = 1'b1;
         end
         plist_pkg::CMD_REM_TAIL: begin
            // empty list wraps here but is caught by the empty check
            is_rem  = 1'b1;
            dec_pos = count_ff - PosW'(1);
         end
         plist_pkg::CMD_REM_AT: begin
            is_rem  = 1'b1;
            dec_pos = req_pos;
         end
         default: begin
            is_ins = 1'b0;
         end
      endcase
   end

   // Sequencer: decode, walk the shift through the RAM, deliver the result
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      end_in       = end_ff;
      value_in     = value_ff;
      taken_in     = taken_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ptr_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ptr_ff;
      ram_wr_data  = ram_rd_data;
      req_tready   = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               value_in  = req_elem;
               taken_in  = '0;
               status_in = plist_pkg::STAT_OK;
               state_in  = S_RESP;
               if (is_ins) begin
                  if (dec_pos > count_ff) begin
                     status_in = plist_pkg::STAT_RANGE;
                  end else if (count_ff == PosW'(CAPACITY)) begin
                     status_in = plist_pkg::STAT_FULL;
                  end else if (dec_pos == count_ff) begin
                     // append: nothing to shift
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = AddrW'(dec_pos);
                     ram_wr_data = req_elem;
                     count_in    = count_ff + PosW'(1);
                  end else begin
                     // start the upward shift at the tail
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = AddrW'(count_ff - PosW'(1));
                     ptr_in      = AddrW'(count_ff - PosW'(1));
                     pos_in      = AddrW'(dec_pos);
                     state_in    = S_INS_SHIFT;
                  end
               end else if (is_rem) begin
                  if (count_ff == '0 || dec_pos >= count_ff) begin
                     status_in = plist_pkg::STAT_RANGE;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = AddrW'(dec_pos);
                     ptr_in      = AddrW'(dec_pos);
                     end_in      = AddrW'(count_ff - PosW'(1));
                     state_in    = S_REM_TAKE;
                  end
               end else begin
                  status_in = plist_pkg::STAT_RANGE;
               end
            end
         end
         S_INS_SHIFT: begin
            // move entry ptr up by one, read the next one down
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff + AddrW'(1);
            if (ptr_ff == pos_ff) begin
               state_in = S_INS_PLACE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_ff - AddrW'(1);
               ptr_in      = ptr_ff - AddrW'(1);
            end
         end
         S_INS_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff;
            ram_wr_data = value_ff;
            count_in    = count_ff + PosW'(1);
            state_in    = S_RESP;
         end
         S_REM_TAKE: begin
            // hold the removed word, then walk the later entries down
            taken_in = ram_rd_data;
            if (ptr_ff == end_ff) begin
               count_in = count_ff - PosW'(1);
               state_in = S_RESP;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_ff + AddrW'(1);
               ptr_in      = ptr_ff + AddrW'(1);
               state_in    = S_REM_SHIFT;
            end
         end
         S_REM_SHIFT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff - AddrW'(1);
            if (ptr_ff == end_ff) begin
               count_in = count_ff - PosW'(1);
               state_in = S_RESP;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_ff + AddrW'(1);
               ptr_in      = ptr_ff + AddrW'(1);
            end
         end
         S_RESP: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RspW'({count_ff, status_ff, taken_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      pos_ff      <= pos_in;
      end_ff      <= end_in;
      value_ff    <= value_in;
      taken_ff    <= taken_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Element store
   plist_ram #(
      .WIDTH (ELEMENT_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire
